FILE: rtl/rrmd_pkg.sv
`default_nettype none

package rrmd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int QDEPTH      = 4;
    localparam int LANE_STAGES = 15;
    localparam int SEL_STAGES  = 3;
    localparam int ROOT_STAGES = 32;
    localparam int PIPE_STAGES = LANE_STAGES + SEL_STAGES + ROOT_STAGES;
    localparam int NUM_LANES   = 8;

    typedef struct packed {
        logic signed [31:0] first_center_x;
        logic signed [31:0] first_center_y;
        logic signed [15:0] first_cos;
        logic signed [15:0] first_sin;
        logic        [30:0] first_width;
        logic        [30:0] first_height;
        logic signed [31:0] second_center_x;
        logic signed [31:0] second_center_y;
        logic signed [15:0] second_cos;
        logic signed [15:0] second_sin;
        logic        [30:0] second_width;
        logic        [30:0] second_height;
    } in_item_t;

    typedef struct packed {
        logic        [31:0] gap_distance;
        logic signed [31:0] near_first_x;
        logic signed [31:0] near_first_y;
        logic signed [31:0] near_second_x;
        logic signed [31:0] near_second_y;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic        [29:0] hx;
        logic        [29:0] hy;
    } rect_t;

    typedef struct packed {
        rect_t r1;
        rect_t r2;
    } pair_t;

    typedef struct packed {
        logic [31:0] f1x;
        logic [31:0] f1y;
        logic [31:0] f2x;
        logic [31:0] f2y;
    } pts_t;

    typedef struct packed {
        logic [63:0] d2;
        pts_t        pts;
    } cand_t;

endpackage

`default_nettype wire

FILE: rtl/rect_rect_min_distance_unit.sv
// rect_rect_min_distance_unit: nearest points between two oriented rectangles
//
// request side: drive request and raise push; the word is taken on a rising
// edge with push high and full low. a four-word queue sits in front of the
// compute pipeline, so full rises only when that queue backs up.
// result side: while empty is low the oldest result is on result; raise pop to
// take it. results leave in the order the requests came in, one per request.
//
// pipeline: an accepted push reaches the result side through the queue, 15 lane
// stages, 3 compare stages and 32 root stages (the queue head feeds the first lane
// stage directly).
// throughput: one word per cycle unless the receiver stalls, set by the eight
// corner test lanes and the square root pipeline, which all take a new word per cycle.
//
// when the receiver stalls with a result waiting, the whole pipeline holds;
// the queue keeps taking words until it fills and then full rises.
// reset clears the queue and all valid flags: full and empty go low and high.
`default_nettype none

module rect_rect_min_distance_unit
    import rrmd_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t request,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    logic  en;
    logic  head_valid;
    pair_t head;
    cand_t cand [NUM_LANES];
    cand_t best;
    logic [PIPE_STAGES-1:0] vld_reg;

    assign en    = !vld_reg[PIPE_STAGES-1] || pop;
    assign empty = !vld_reg[PIPE_STAGES-1];

    rrmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .take       (en),
        .head_valid (head_valid),
        .head       (head)
    );

    // lanes 0-3: corners of two against one, lanes 4-7: corners of one against two
    for (genvar k = 0; k < NUM_LANES; k++)
    begin : g_lane
        localparam int C = k % 4;
        logic [31:0] gx, gy, nx, ny;
        logic [63:0] d2;

        rrmd_lane #(
            .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
        ) u_lane (
            .clk      (clk),
            .en       (en),
            .own      ((k < 4) ? head.r2 : head.r1),
            .oth      ((k < 4) ? head.r1 : head.r2),
            .neg_x    (C >= 2),
            .neg_y    (C == 1 || C == 2),
            .dist2    (d2),
            .corner_x (gx),
            .corner_y (gy),
            .near_x   (nx),
            .near_y   (ny)
        );

        always_comb
        begin
            cand[k].d2 = d2;
            if (k < 4)
            begin
                cand[k].pts = '{f1x: nx, f1y: ny, f2x: gx, f2y: gy};
            end
            else
            begin
                cand[k].pts = '{f1x: gx, f1y: gy, f2x: nx, f2y: ny};
            end
        end
    end

    rrmd_select u_select (
        .clk  (clk),
        .en   (en),
        .cand (cand),
        .best (best)
    );

    rrmd_isqrt u_isqrt (
        .clk    (clk),
        .en     (en),
        .best   (best),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], head_valid};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rrmd_front.sv
`default_nettype none

module rrmd_front
    import rrmd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t request,
    input  wire logic     take,
    output logic          head_valid,
    output pair_t         head
);

    localparam int PTR_W = $clog2(QDEPTH);

    pair_t            mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             wr, rd;
    pair_t            item;

    // half extents drop the lsb of the full extent
    always_comb
    begin
        item.r1.cx = request.first_center_x;
        item.r1.cy = request.first_center_y;
        item.r1.c  = request.first_cos;
        item.r1.s  = request.first_sin;
        item.r1.hx = request.first_width[30:1];
        item.r1.hy = request.first_height[30:1];
        item.r2.cx = request.second_center_x;
        item.r2.cy = request.second_center_y;
        item.r2.c  = request.second_cos;
        item.r2.s  = request.second_sin;
        item.r2.hx = request.second_width[30:1];
        item.r2.hy = request.second_height[30:1];
    end

    assign full       = (count_reg == (PTR_W+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign wr         = push && !full;
    assign rd         = take && head_valid;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rrmd_lane.sv
`default_nettype none

module rrmd_lane
    import rrmd_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 14
)
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire rect_t own,
    input  wire rect_t oth,
    input  wire logic  neg_x,
    input  wire logic  neg_y,
    output logic [63:0] dist2,
    output logic [31:0] corner_x,
    output logic [31:0] corner_y,
    output logic [31:0] near_x,
    output logic [31:0] near_y
);

    localparam int F  = TRIG_FRAC_BITS;
    localparam int PW = 48;
    localparam int TW = PW - F;
    localparam int GW = ((TW > 32) ? TW : 32) + 1;
    localparam int DW = GW + 1;
    localparam int QW = DW + 17;
    localparam int LW = QW - F;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam logic [31:0] MAG_MAX = 32'hFFFF_FFFF;

    function automatic logic [31:0] sat_out(input logic signed [GW-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (w > SAT_HI)
        begin
            w = SAT_HI;
        end
        else if (w < SAT_LO)
        begin
            w = SAT_LO;
        end
        return w[31:0];
    endfunction

    rect_t              oth_reg [1:10];
    logic signed [31:0] own_cx_reg [1:2];
    logic signed [31:0] own_cy_reg [1:2];
    logic signed [GW-1:0] gx_reg [3:12];
    logic signed [GW-1:0] gy_reg [3:12];

    logic signed [30:0] own_hx, own_hy, cqx, cqy;
    logic signed [PW-1:0] p1a_reg, p1b_reg, p1c_reg, p1d_reg;
    logic signed [PW-1:0] s2x, s2y;
    logic signed [TW-1:0] t2x_reg, t2y_reg;
    logic signed [DW-1:0] dx4_reg, dy4_reg;
    logic signed [QW-1:0] m5a_reg, m5b_reg, m5c_reg, m5d_reg;
    logic signed [QW-1:0] s6x, s6y;
    logic signed [LW-1:0] lx6_reg, ly6_reg, lx7_reg, ly7_reg;
    logic signed [LW-1:0] hxl, hyl;
    logic        [LW-1:0] alx7_reg, aly7_reg;
    logic                 inx7_reg, iny7_reg;
    logic signed [30:0] oth_hx, oth_hy;
    logic        [30:0] bx, by;
    logic               both_in, x_wins, use_x, use_y;
    logic signed [30:0] q8x_reg, q8y_reg;
    logic signed [PW-1:0] p9a_reg, p9b_reg, p9c_reg, p9d_reg;
    logic signed [PW-1:0] s10x, s10y;
    logic signed [TW-1:0] t10x_reg, t10y_reg;
    logic signed [GW-1:0] ox11_reg, oy11_reg, ox12_reg, oy12_reg;
    logic signed [DW-1:0] ex12_reg, ey12_reg;
    logic        [DW-1:0] aex, aey;
    logic        [31:0] ex13_reg, ey13_reg;
    logic        [31:0] cx_reg [13:15];
    logic        [31:0] cy_reg [13:15];
    logic        [31:0] nx_reg [13:15];
    logic        [31:0] ny_reg [13:15];
    logic        [63:0] sqx14_reg, sqy14_reg;
    logic        [64:0] sum15;
    logic        [63:0] dist15_reg;

    always_comb
    begin
        own_hx = $signed({1'b0, own.hx});
        own_hy = $signed({1'b0, own.hy});
        cqx    = neg_x ? -own_hx : own_hx;
        cqy    = neg_y ? -own_hy : own_hy;

        s2x = p1a_reg - p1b_reg + PW'(1 << (F - 1));
        s2y = p1c_reg + p1d_reg + PW'(1 << (F - 1));

        s6x = m5a_reg + m5b_reg + QW'(1 << (F - 1));
        s6y = m5c_reg - m5d_reg + QW'(1 << (F - 1));

        hxl = LW'($signed({1'b0, oth_reg[6].hx}));
        hyl = LW'($signed({1'b0, oth_reg[6].hy}));

        // inside on both axes: push out through the nearer edge, x wins a tie
        oth_hx  = $signed({1'b0, oth_reg[7].hx});
        oth_hy  = $signed({1'b0, oth_reg[7].hy});
        bx      = {1'b0, oth_reg[7].hx} - alx7_reg[30:0];
        by      = {1'b0, oth_reg[7].hy} - aly7_reg[30:0];
        both_in = inx7_reg && iny7_reg;
        x_wins  = (bx <= by);
        use_x   = inx7_reg && !(both_in && x_wins);
        use_y   = iny7_reg && !(both_in && !x_wins);

        s10x = p9a_reg - p9b_reg + PW'(1 << (F - 1));
        s10y = p9c_reg + p9d_reg + PW'(1 << (F - 1));

        aex = ex12_reg[DW-1] ? DW'(-ex12_reg) : DW'(ex12_reg);
        aey = ey12_reg[DW-1] ? DW'(-ey12_reg) : DW'(ey12_reg);

        sum15 = {1'b0, sqx14_reg} + {1'b0, sqy14_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oth_reg[1] <= oth;
            for (int i = 2; i <= 10; i++)
            begin
                oth_reg[i] <= oth_reg[i-1];
            end
            own_cx_reg[1] <= own.cx;
            own_cy_reg[1] <= own.cy;
            own_cx_reg[2] <= own_cx_reg[1];
            own_cy_reg[2] <= own_cy_reg[1];

            // corner of own rectangle into the global frame
            p1a_reg <= PW'(own.c) * PW'(cqx);
            p1b_reg <= PW'(own.s) * PW'(cqy);
            p1c_reg <= PW'(own.s) * PW'(cqx);
            p1d_reg <= PW'(own.c) * PW'(cqy);
            t2x_reg <= s2x[PW-1:F];
            t2y_reg <= s2y[PW-1:F];
            gx_reg[3] <= GW'(own_cx_reg[2]) + GW'(t2x_reg);
            gy_reg[3] <= GW'(own_cy_reg[2]) + GW'(t2y_reg);
            for (int i = 4; i <= 12; i++)
            begin
                gx_reg[i] <= gx_reg[i-1];
                gy_reg[i] <= gy_reg[i-1];
            end

            // into the other rectangle's frame
            dx4_reg <= DW'(gx_reg[3]) - DW'(oth_reg[3].cx);
            dy4_reg <= DW'(gy_reg[3]) - DW'(oth_reg[3].cy);
            m5a_reg <= QW'(oth_reg[4].c) * QW'(dx4_reg);
            m5b_reg <= QW'(oth_reg[4].s) * QW'(dy4_reg);
            m5c_reg <= QW'(oth_reg[4].c) * QW'(dy4_reg);
            m5d_reg <= QW'(oth_reg[4].s) * QW'(dx4_reg);
            lx6_reg <= s6x[QW-1:F];
            ly6_reg <= s6y[QW-1:F];

            lx7_reg  <= lx6_reg;
            ly7_reg  <= ly6_reg;
            inx7_reg <= (lx6_reg > -hxl) && (lx6_reg < hxl);
            iny7_reg <= (ly6_reg > -hyl) && (ly6_reg < hyl);
            alx7_reg <= lx6_reg[LW-1] ? LW'(-lx6_reg) : LW'(lx6_reg);
            aly7_reg <= ly6_reg[LW-1] ? LW'(-ly6_reg) : LW'(ly6_reg);

            q8x_reg <= use_x ? $signed(lx7_reg[30:0]) : (lx7_reg[LW-1] ? -oth_hx : oth_hx);
            q8y_reg <= use_y ? $signed(ly7_reg[30:0]) : (ly7_reg[LW-1] ? -oth_hy : oth_hy);

            // clamped point back to the global frame
            p9a_reg  <= PW'(oth_reg[8].c) * PW'(q8x_reg);
            p9b_reg  <= PW'(oth_reg[8].s) * PW'(q8y_reg);
            p9c_reg  <= PW'(oth_reg[8].s) * PW'(q8x_reg);
            p9d_reg  <= PW'(oth_reg[8].c) * PW'(q8y_reg);
            t10x_reg <= s10x[PW-1:F];
            t10y_reg <= s10y[PW-1:F];
            ox11_reg <= GW'(oth_reg[10].cx) + GW'(t10x_reg);
            oy11_reg <= GW'(oth_reg[10].cy) + GW'(t10y_reg);

            ox12_reg <= ox11_reg;
            oy12_reg <= oy11_reg;
            ex12_reg <= DW'(ox11_reg) - DW'(gx_reg[11]);
            ey12_reg <= DW'(oy11_reg) - DW'(gy_reg[11]);

            ex13_reg <= (aex > DW'(MAG_MAX)) ? MAG_MAX : aex[31:0];
            ey13_reg <= (aey > DW'(MAG_MAX)) ? MAG_MAX : aey[31:0];
            cx_reg[13] <= sat_out(gx_reg[12]);
            cy_reg[13] <= sat_out(gy_reg[12]);
            nx_reg[13] <= sat_out(ox12_reg);
            ny_reg[13] <= sat_out(oy12_reg);
            for (int i = 14; i <= 15; i++)
            begin
                cx_reg[i] <= cx_reg[i-1];
                cy_reg[i] <= cy_reg[i-1];
                nx_reg[i] <= nx_reg[i-1];
                ny_reg[i] <= ny_reg[i-1];
            end

            sqx14_reg  <= {32'b0, ex13_reg} * {32'b0, ex13_reg};
            sqy14_reg  <= {32'b0, ey13_reg} * {32'b0, ey13_reg};
            dist15_reg <= sum15[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum15[63:0];
        end
    end

    assign dist2    = dist15_reg;
    assign corner_x = cx_reg[15];
    assign corner_y = cy_reg[15];
    assign near_x   = nx_reg[15];
    assign near_y   = ny_reg[15];

endmodule

`default_nettype wire

FILE: rtl/rrmd_select.sv
`default_nettype none

module rrmd_select
    import rrmd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire cand_t cand [NUM_LANES],
    output cand_t      best
);

    cand_t l1_reg [4];
    cand_t l2_reg [2];
    cand_t l3_reg;

    // strict compare keeps the earlier test on a tie
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                l1_reg[i] <= (cand[2*i+1].d2 < cand[2*i].d2) ? cand[2*i+1] : cand[2*i];
            end
            for (int i = 0; i < 2; i++)
            begin
                l2_reg[i] <= (l1_reg[2*i+1].d2 < l1_reg[2*i].d2) ? l1_reg[2*i+1] : l1_reg[2*i];
            end
            l3_reg <= (l2_reg[1].d2 < l2_reg[0].d2) ? l2_reg[1] : l2_reg[0];
        end
    end

    assign best = l3_reg;

endmodule

`default_nettype wire

FILE: rtl/rrmd_isqrt.sv
`default_nettype none

module rrmd_isqrt
    import rrmd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire cand_t best,
    output out_item_t  result
);

    logic [63:0] v_reg [ROOT_STAGES];
    logic [63:0] r_reg [ROOT_STAGES];
    pts_t        p_reg [ROOT_STAGES];

    // one result bit per stage, restoring square root
    for (genvar i = 0; i < ROOT_STAGES; i++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] v_in, r_in, v_next, r_next;
        logic [64:0] trial;
        pts_t        p_in;
        logic        ge;

        always_comb
        begin
            if (i == 0)
            begin
                v_in = best.d2;
                r_in = '0;
                p_in = best.pts;
            end
            else
            begin
                v_in = v_reg[(i == 0) ? 0 : i - 1];
                r_in = r_reg[(i == 0) ? 0 : i - 1];
                p_in = p_reg[(i == 0) ? 0 : i - 1];
            end
            trial  = {1'b0, r_in} + {1'b0, BIT};
            ge     = ({1'b0, v_in} >= trial);
            v_next = ge ? v_in - trial[63:0] : v_in;
            r_next = ge ? (r_in >> 1) + BIT : (r_in >> 1);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[i] <= v_next;
                r_reg[i] <= r_next;
                p_reg[i] <= p_in;
            end
        end
    end

    always_comb
    begin
        result.gap_distance  = r_reg[ROOT_STAGES-1][31:0];
        result.near_first_x  = p_reg[ROOT_STAGES-1].f1x;
        result.near_first_y  = p_reg[ROOT_STAGES-1].f1y;
        result.near_second_x = p_reg[ROOT_STAGES-1].f2x;
        result.near_second_y = p_reg[ROOT_STAGES-1].f2y;
    end

endmodule

`default_nettype wire

FILE: rtl/rrmd_checker.sv
`default_nettype none

module rrmd_checker
    import rrmd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      push,
    input wire logic      full,
    input wire logic      empty,
    input wire logic      pop,
    input wire out_item_t result
);

    localparam int MAX_OUT = QDEPTH + PIPE_STAGES;

    logic [6:0] outstanding_reg, outstanding_next;
    logic       in_acc, out_acc;

    assign in_acc  = push && !full;
    assign out_acc = pop && !empty;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_acc && !out_acc)
        begin
            outstanding_next = outstanding_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // the valid flags clear asynchronously in reset; the check looks at the following edge
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outstanding_reg != '0))
        else $error("result without a pending request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 7'(MAX_OUT))
        else $error("more words in flight than the block can hold");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("stalled result changed");

endmodule

bind rect_rect_min_distance_unit rrmd_checker u_rrmd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire
